### sv/rpa_pkg.sv
// Package for the register pool allocator: operation and status codes.
// Used by all modules of the allocator; no dependencies.
package rpa_pkg;
	localparam int NumRegsDef     = 16;
	localparam int ValueIdBitsDef = 16;

	localparam logic [1:0] OP_ALLOC     = 2'd0;
	localparam logic [1:0] OP_FORCE     = 2'd1;
	localparam logic [1:0] OP_FREE_VAL  = 2'd2;
	localparam logic [1:0] OP_FREE_REG  = 2'd3;

	localparam logic [2:0] ST_DONE    = 3'd0;
	localparam logic [2:0] ST_HELD    = 3'd1;
	localparam logic [2:0] ST_EVICT   = 3'd2;
	localparam logic [2:0] ST_FAIL    = 3'd3;
	localparam logic [2:0] ST_INVALID = 3'd4;
	localparam logic [2:0] ST_NONE    = 3'd5;

	typedef struct packed {
		logic load;
		logic exec;
		logic emit;
	} rpa_cmd_t;

	typedef struct packed {
		logic out_busy;
	} rpa_stat_t;
endpackage

### sv/rpa_ctrl.sv
// Controller for the register pool allocator: accept, execute, present.
// Depends on rpa_pkg.
module rpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rpa_pkg::rpa_stat_t stat,
	output rpa_pkg::rpa_cmd_t  cmd
);
	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_EXEC = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!stat.out_busy) begin
					cmd.exec = 1'b1;
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### sv/rpa_dp.sv
// Datapath for the register pool allocator: masks, owner tags, age queue, result.
// Depends on rpa_pkg.
module rpa_dp #(
	parameter int NUM_REGS      = rpa_pkg::NumRegsDef,
	parameter int VALUE_ID_BITS = rpa_pkg::ValueIdBitsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rpa_pkg::rpa_cmd_t  cmd,
	output rpa_pkg::rpa_stat_t stat,
	input  logic [1:0]         op,
	input  logic               has_value,
	input  logic [15:0]        value_id,
	input  logic               req_valid,
	input  logic [3:0]         reg_num,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [3:0]         reg_out,
	output logic [15:0]        spilled_value,
	output logic [15:0]        busy_mask,
	output logic [15:0]        used_mask
);
	localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int CW = $clog2(NUM_REGS + 1);

	logic [1:0]               op_q;
	logic                     hv_q;
	logic [VALUE_ID_BITS-1:0] tag_q;
	logic                     rv_q;
	logic [3:0]               rn_q;

	logic [NUM_REGS-1:0]      busy_q, used_q, ov_q;
	logic [VALUE_ID_BITS-1:0] tag_mem [NUM_REGS];
	logic [RW-1:0]            age_q [NUM_REGS];
	logic [CW-1:0]            cnt_q;

	logic                     hit;
	logic [RW-1:0]            hit_r;
	logic                     free_f;
	logic [RW-1:0]            free_r;
	logic                     rn_ok;
	logic [RW-1:0]            rn_r;

	always_comb begin
		hit = 1'b0;
		hit_r = '0;
		for (int i = NUM_REGS - 1; i >= 0; i--) begin
			if (ov_q[i] && tag_mem[i] == tag_q) begin
				hit = 1'b1;
				hit_r = RW'(i);
			end
		end
		free_f = 1'b0;
		free_r = '0;
		for (int i = NUM_REGS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_f = 1'b1;
				free_r = RW'(i);
			end
		end
		rn_ok = 32'(rn_q) < NUM_REGS;
		rn_r  = RW'(rn_q);
	end

	logic [NUM_REGS-1:0] busy_d, used_d, ov_d;
	logic                drop_en, push_en, wr_tag;
	logic [RW-1:0]       drop_r, push_r;
	logic [2:0]          st_d;
	logic [3:0]          ro_d;
	logic [VALUE_ID_BITS-1:0] sp_d;
	logic [RW-1:0]       tgt;

	always_comb begin
		busy_d = busy_q;
		used_d = used_q;
		ov_d   = ov_q;
		drop_en = 1'b0;
		drop_r  = '0;
		push_en = 1'b0;
		push_r  = '0;
		wr_tag  = 1'b0;
		st_d    = rpa_pkg::ST_DONE;
		ro_d    = '0;
		sp_d    = '0;
		tgt     = '0;
		unique case (op_q)
			rpa_pkg::OP_ALLOC: begin
				if (hv_q && hit) begin
					busy_d[hit_r] = 1'b1;
					used_d[hit_r] = 1'b1;
					drop_en = 1'b1;
					drop_r  = hit_r;
					push_en = 1'b1;
					push_r  = hit_r;
					st_d    = rpa_pkg::ST_HELD;
					ro_d    = 4'(hit_r);
				end else if ((rv_q && rn_ok && !busy_q[rn_r]) || free_f
						|| cnt_q != '0) begin
					if (rv_q && rn_ok && !busy_q[rn_r]) begin
						tgt = rn_r;
					end else if (free_f) begin
						tgt = free_r;
					end else begin
						tgt = age_q[0];
						sp_d = tag_mem[age_q[0]];
						st_d = rpa_pkg::ST_EVICT;
						ov_d[tgt] = 1'b0;
						drop_en = 1'b1;
						drop_r  = tgt;
					end
					busy_d[tgt] = 1'b1;
					used_d[tgt] = 1'b1;
					if (hv_q) begin
						ov_d[tgt] = 1'b1;
						wr_tag  = 1'b1;
						push_en = 1'b1;
						push_r  = tgt;
					end
					ro_d = 4'(tgt);
				end else begin
					st_d = rpa_pkg::ST_FAIL;
				end
			end
			rpa_pkg::OP_FORCE: begin
				if (!rn_ok) begin
					st_d = rpa_pkg::ST_INVALID;
				end else begin
					if (busy_q[rn_r] && ov_q[rn_r]) begin
						ov_d[rn_r] = 1'b0;
						drop_en = 1'b1;
						drop_r  = rn_r;
					end
					busy_d[rn_r] = 1'b1;
					used_d[rn_r] = 1'b1;
					ro_d = rn_q;
				end
			end
			rpa_pkg::OP_FREE_VAL: begin
				if (hit) begin
					busy_d[hit_r] = 1'b0;
					ov_d[hit_r] = 1'b0;
					drop_en = 1'b1;
					drop_r  = hit_r;
					ro_d = 4'(hit_r);
				end else begin
					st_d = rpa_pkg::ST_NONE;
				end
			end
			rpa_pkg::OP_FREE_REG: begin
				if (!rn_ok) begin
					st_d = rpa_pkg::ST_INVALID;
				end else begin
					busy_d[rn_r] = 1'b0;
					if (ov_q[rn_r]) begin
						ov_d[rn_r] = 1'b0;
						drop_en = 1'b1;
						drop_r  = rn_r;
					end
					if (busy_q[rn_r]) begin
						ro_d = rn_q;
					end else begin
						st_d = rpa_pkg::ST_NONE;
					end
				end
			end
			default: st_d = rpa_pkg::ST_FAIL;
		endcase
	end

	// compact the age queue around the dropped entry, then append
	logic                dropped;
	logic [RW-1:0]       age_d [NUM_REGS];
	logic [CW-1:0]       cnt_d;

	always_comb begin
		dropped = 1'b0;
		for (int i = 0; i < NUM_REGS; i++) begin
			if ((CW'(i) < cnt_q) && drop_en && age_q[i] == drop_r) begin
				dropped = 1'b1;
			end
			if (dropped && i + 1 < NUM_REGS) begin
				age_d[i] = age_q[(i + 1) % NUM_REGS];
			end else begin
				age_d[i] = age_q[i];
			end
		end
		cnt_d = cnt_q - CW'(dropped);
		if (push_en && cnt_d < CW'(NUM_REGS)) begin
			age_d[cnt_d[RW-1:0]] = push_r;
			cnt_d = cnt_d + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= '0;
			used_q    <= '0;
			ov_q      <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.exec) begin
				busy_q <= busy_d;
				used_q <= used_d;
				ov_q   <= ov_d;
				cnt_q  <= cnt_d;
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			hv_q  <= has_value;
			tag_q <= value_id[VALUE_ID_BITS-1:0];
			rv_q  <= req_valid;
			rn_q  <= reg_num;
		end
		if (cmd.exec) begin
			if (wr_tag) begin
				tag_mem[tgt] <= tag_q;
			end
			for (int i = 0; i < NUM_REGS; i++) begin
				age_q[i] <= age_d[i];
			end
		end
		if (cmd.emit) begin
			status        <= st_d;
			reg_out       <= ro_d;
			spilled_value <= 16'(sp_d);
			busy_mask     <= 16'(busy_d);
			used_mask     <= 16'(used_d);
		end
	end

	assign stat.out_busy = out_valid && !out_ready;
endmodule

### sv/register_pool_allocator_fifo_spill.sv
// Register pool allocator with oldest-first eviction.
// Slave channel s_axis_* carries one request transaction; master channel
// m_axis_* carries one result transaction per request.
// A request is captured in the request register while idle and executed once
// the output is not busy, when the result register is loaded; the next request
// is taken the cycle after the result is loaded, so a new request is not taken
// before the last one has its result. The owner search and age-queue compaction
// run combinationally between the request register and the result register.
// Reset clears the busy and used masks, owner valid bits and the queue count;
// owner tags and queue entries are written before they are read.
// While the receiver stalls, the result register holds and the block does
// not execute the next request; s_axis_tready stays low after one request
// has been captured.
// Depends on rpa_pkg, rpa_ctrl, rpa_dp.
module register_pool_allocator_fifo_spill #(
	parameter int NUM_REGS      = rpa_pkg::NumRegsDef,
	parameter int VALUE_ID_BITS = rpa_pkg::ValueIdBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // op, has_value, value_id, req_valid, reg_num
	input  logic        m_axis_tready,
	output logic        m_axis_tvalid,
	output logic [55:0] m_axis_tdata   // status, reg_out, spilled_value, busy_mask, used_mask
);
	rpa_pkg::rpa_cmd_t  cmd;
	rpa_pkg::rpa_stat_t stat;
	logic [2:0]  status;
	logic [3:0]  reg_out;
	logic [15:0] spilled_value, busy_mask, used_mask;

	rpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rpa_dp #(.NUM_REGS(NUM_REGS), .VALUE_ID_BITS(VALUE_ID_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.op            (s_axis_tdata[1:0]),
		.has_value     (s_axis_tdata[2]),
		.value_id      (s_axis_tdata[18:3]),
		.req_valid     (s_axis_tdata[19]),
		.reg_num       (s_axis_tdata[23:20]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.status        (status),
		.reg_out       (reg_out),
		.spilled_value (spilled_value),
		.busy_mask     (busy_mask),
		.used_mask     (used_mask)
	);

	assign m_axis_tdata = {1'b0, used_mask, busy_mask, spilled_value, reg_out, status};

	a_no_accept_while_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted during execution");
	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !cmd.load)
		else $error("load and emit together");
	a_used_covers_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[38:23] & ~m_axis_tdata[54:39]) == 16'd0))
		else $error("busy register not marked used");
endmodule
